@@ rtl/urhb_pkg.sv @@
`timescale 1ns / 1ps
// urhb_pkg: shared types and constants for the undo/redo history buffer
// no dependencies; imported by urhb_ctrl, urhb_dpath and the top level
package urhb_pkg;

    // fixed field widths of the channel words
    localparam int unsigned HANDLE_W  = 32;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned CFG_W     = 5;

    // reset value of the max_length register
    localparam logic [CFG_W-1:0] MAX_LEN_RST = 5'd16;

    // input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_UNDO  = 2'd1,
        CMD_REDO  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // result action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE   = 2'd0,
        ACT_EXEC   = 2'd1,
        ACT_UNEXEC = 2'd2
    } t_action;

    // kind of the last history step
    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_UNDO = 2'd1,
        KIND_REDO = 2'd2
    } t_kind;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ACT,
        ST_RD_UNDO,
        ST_RD_REDO,
        ST_FINISH
    } t_state;

    // which history slot the memory read port looks at
    typedef enum logic [1:0] {
        RD_NONE,
        RD_ACT,
        RD_UNDO,
        RD_REDO
    } t_rd_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic    accept;
        t_rd_sel rd_sel;
        logic    cap_act;
        logic    cap_undo;
        logic    load_out;
    } t_dp_cmd;

    // input word
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] entry_handle;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [HANDLE_W-1:0] action_handle;
        logic                refused;
        logic                undo_possible;
        logic                redo_possible;
        logic [HANDLE_W-1:0] next_undo_handle;
        logic [HANDLE_W-1:0] next_redo_handle;
    } t_out_word;

endpackage

@@ rtl/urhb_ctrl.sv @@
`timescale 1ns / 1ps
// urhb_ctrl: controller state machine sequencing accept, three history reads
// and the output register load; depends on urhb_pkg
module urhb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output urhb_pkg::t_dp_cmd o_cmd
);
    import urhb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_load;

    // output register can take a word when empty or being drained
    assign can_load    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RD_ACT;
            end
            ST_RD_ACT:  n_state = ST_RD_UNDO;
            ST_RD_UNDO: n_state = ST_RD_REDO;
            ST_RD_REDO: n_state = ST_FINISH;
            ST_FINISH: begin
                if (can_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands and input stall
    always_comb begin
        o_in_stall     = 1'b1;
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_RD_ACT: begin
                o_cmd.rd_sel = RD_ACT;
            end
            ST_RD_UNDO: begin
                o_cmd.rd_sel  = RD_UNDO;
                o_cmd.cap_act = 1'b1;
            end
            ST_RD_REDO: begin
                o_cmd.rd_sel   = RD_REDO;
                o_cmd.cap_undo = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.load_out = can_load;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/urhb_dpath.sv @@
`timescale 1ns / 1ps
// urhb_dpath: history memory, ring pointer, cursor, step kind, limit register
// and result registers; depends on urhb_pkg
module urhb_dpath #(
    parameter int unsigned HISTORY_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata,
    input  urhb_pkg::t_in_word   i_in_word,
    input  urhb_pkg::t_dp_cmd    i_cmd,
    output urhb_pkg::t_out_word  o_out_word
);
    import urhb_pkg::*;

    localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

    // ring slot of logical entry idx
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] oldest,
                                              input logic [CW-1:0] idx);
        logic [SW-1:0] s;
        s = SW'(oldest) + SW'(idx);
        if (s >= SW'(HISTORY_DEPTH)) s = s - SW'(HISTORY_DEPTH);
        return AW'(s);
    endfunction

    function automatic logic undo_ok(input logic [CW-1:0] cnt,
                                     input logic [CW-1:0] cur,
                                     input t_kind kind);
        return (cnt != '0) && ((kind == KIND_REDO) || (cur != '0));
    endfunction

    function automatic logic redo_ok(input logic [CW-1:0] cnt,
                                     input logic [CW-1:0] cur,
                                     input t_kind kind);
        logic ok;
        case (kind)
            KIND_UNDO: ok = 1'b1;
            KIND_REDO: ok = (SW'(cur) + SW'(1)) < SW'(cnt);
            KIND_ADD:  ok = cur < cnt;
            default:   ok = 1'b0;
        endcase
        return (cnt != '0) && ok;
    endfunction

    // history memory
    logic [HANDLE_W-1:0] r_mem [HISTORY_DEPTH];
    logic [HANDLE_W-1:0] r_rd_data;

    // history state
    logic [AW-1:0]    r_oldest, n_oldest;
    logic [CW-1:0]    r_count,  n_count;
    logic [CW-1:0]    r_cursor, n_cursor;
    t_kind            r_kind,   n_kind;
    logic [CFG_W-1:0] r_max_len;

    // per-item result fields
    t_action          r_action, n_action;
    logic             r_refused, n_refused;
    logic             r_undo_ok, n_undo_ok;
    logic             r_redo_ok, n_redo_ok;
    logic [AW-1:0]    r_act_slot, r_undo_slot, r_redo_slot;
    logic [AW-1:0]    n_act_slot, n_undo_slot, n_redo_slot;
    logic [HANDLE_W-1:0] r_act_handle, r_undo_handle;
    t_out_word        r_out_word;

    logic [LW-1:0]    max_ext, lim;
    logic             full;
    logic             we;
    logic [AW-1:0]    wslot;
    logic [CW-1:0]    act_idx, undo_idx, redo_idx;
    logic [AW-1:0]    rd_addr;
    logic [HANDLE_W-1:0] rd_word;

    // effective limit clamped to 1..depth
    always_comb begin
        max_ext = LW'(r_max_len);
        if (max_ext == '0) begin
            lim = LW'(1);
        end else if (max_ext > LW'(HISTORY_DEPTH)) begin
            lim = LW'(HISTORY_DEPTH);
        end else begin
            lim = max_ext;
        end
        full = LW'(r_count) >= lim;
    end

    // step update on accept
    always_comb begin
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_kind    = r_kind;
        n_action  = ACT_NONE;
        n_refused = 1'b0;
        we        = 1'b0;
        wslot     = slot_of(r_oldest, r_count);
        if (i_cmd.accept) begin
            case (t_cmd'(i_in_word.command))
                CMD_ADD: begin
                    we = 1'b1;
                    if (full) begin
                        // evict oldest, count stays
                        n_oldest = slot_of(r_oldest, CW'(1));
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    n_cursor = n_count;
                    n_kind   = KIND_ADD;
                end
                CMD_UNDO: begin
                    if (!undo_ok(r_count, r_cursor, r_kind)) begin
                        n_refused = 1'b1;
                    end else begin
                        if (r_kind == KIND_REDO) n_kind = KIND_UNDO;
                        else n_cursor = r_cursor - CW'(1);
                        n_action = ACT_UNEXEC;
                    end
                end
                CMD_REDO: begin
                    if (!redo_ok(r_count, r_cursor, r_kind)) begin
                        n_refused = 1'b1;
                    end else begin
                        if (r_kind == KIND_REDO) n_cursor = r_cursor + CW'(1);
                        else n_kind = KIND_REDO;
                        n_action = ACT_EXEC;
                    end
                end
                CMD_CLEAR: begin
                    n_oldest = '0;
                    n_count  = '0;
                    n_cursor = '0;
                    n_kind   = KIND_ADD;
                end
                default: begin
                    n_refused = 1'b0;
                end
            endcase
        end
    end

    // post-step flags and slots to read
    always_comb begin
        n_undo_ok   = undo_ok(n_count, n_cursor, n_kind);
        n_redo_ok   = redo_ok(n_count, n_cursor, n_kind);
        act_idx     = n_cursor;
        undo_idx    = (n_kind == KIND_REDO) ? n_cursor : n_cursor - CW'(1);
        redo_idx    = (n_kind == KIND_REDO) ? n_cursor + CW'(1) : n_cursor;
        n_act_slot  = slot_of(n_oldest, act_idx);
        n_undo_slot = slot_of(n_oldest, undo_idx);
        n_redo_slot = slot_of(n_oldest, redo_idx);
    end

    // read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_ACT:  rd_addr = r_act_slot;
            RD_UNDO: rd_addr = r_undo_slot;
            RD_REDO: rd_addr = r_redo_slot;
            default: rd_addr = r_act_slot;
        endcase
    end

    assign rd_word = r_rd_data;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wslot] <= i_in_word.entry_handle;
        if (i_cmd.rd_sel != RD_NONE) r_rd_data <= r_mem[rd_addr];
    end

    // history state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_count   <= '0;
            r_cursor  <= '0;
            r_kind    <= KIND_ADD;
            r_max_len <= MAX_LEN_RST;
        end else begin
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_kind   <= n_kind;
            if (i_cfg_we) r_max_len <= i_cfg_wdata;
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action    <= n_action;
            r_refused   <= n_refused;
            r_undo_ok   <= n_undo_ok;
            r_redo_ok   <= n_redo_ok;
            r_act_slot  <= n_act_slot;
            r_undo_slot <= n_undo_slot;
            r_redo_slot <= n_redo_slot;
        end
        if (i_cmd.cap_act) begin
            r_act_handle <= (r_action == ACT_NONE) ? '0 : rd_word;
        end
        if (i_cmd.cap_undo) begin
            r_undo_handle <= r_undo_ok ? rd_word : '0;
        end
        if (i_cmd.load_out) begin
            r_out_word.action           <= r_action;
            r_out_word.action_handle    <= r_act_handle;
            r_out_word.refused          <= r_refused;
            r_out_word.undo_possible    <= r_undo_ok;
            r_out_word.redo_possible    <= r_redo_ok;
            r_out_word.next_undo_handle <= r_undo_handle;
            r_out_word.next_redo_handle <= r_redo_ok ? rd_word : '0;
        end
    end

    assign o_out_word = r_out_word;

endmodule

@@ rtl/undo_redo_history_buffer.sv @@
`timescale 1ns / 1ps
// undo_redo_history_buffer: bounded undo/redo history of entry handles
// sequence: after the input accept, three reads of the history memory (action,
//   next-undo, next-redo) through its single read port, then the output load;
//   a new input word is accepted only after the previous result is loaded into
//   the output register, which waits while the output is stalled
// reset: synchronous active low; empties the history, max_length returns to 16,
//   history memory contents are not cleared
module undo_redo_history_buffer #(
    parameter int unsigned HISTORY_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  urhb_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output urhb_pkg::t_out_word  o_out_word
);
    import urhb_pkg::*;

    t_dp_cmd dp_cmd;

    // sequencer
    urhb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // history storage and result datapath
    urhb_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (dp_cmd),
        .o_out_word  (o_out_word)
    );

endmodule
